// File: rtl/alft_pkg.sv
// Shared types, codes and helpers for the access log field tokenizer.
// No dependencies; imported by every module of the block but alft_checker.
`default_nettype none

package alft_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned LimitWidth  = 16;
   localparam int unsigned FieldWidth  = 8;
   localparam int unsigned CsrIdxWidth = 8;

   localparam logic [ByteWidth-1:0]  CH_QUOTE     = 8'h22;
   localparam logic [ByteWidth-1:0]  CH_OPEN_BR   = 8'h5B;
   localparam logic [ByteWidth-1:0]  CH_CLOSE_BR  = 8'h5D;
   localparam logic [ByteWidth-1:0]  CH_BACKSLASH = 8'h5C;
   localparam logic [FieldWidth-1:0] FIELD_MAX    = 8'hFF;

   localparam logic [LimitWidth-1:0] MAX_LINE_RESET  = 16'd8192;
   localparam logic [LimitWidth-1:0] MAX_FIELD_RESET = 16'd4096;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_MAX_LINE  = 8'd0,
      CSR_MAX_FIELD = 8'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      MODE_BETWEEN = 3'd0,
      MODE_BARE    = 3'd1,
      MODE_QUOTE   = 3'd2,
      MODE_ESCAPE  = 3'd3,
      MODE_BRACKET = 3'd4
   } scan_mode_type;

   typedef enum logic [1:0] {
      KIND_BARE    = 2'd0,
      KIND_QUOTED  = 2'd1,
      KIND_BRACKET = 2'd2
   } field_kind_type;

   typedef struct packed {
      logic [LimitWidth-1:0] line_limit;
      logic [LimitWidth-1:0] field_cap;
   } cfg_type;

   typedef struct packed {
      logic                  has_byte;
      logic [ByteWidth-1:0]  out_byte;
      logic                  field_end;
      field_kind_type        field_kind;
      logic [FieldWidth-1:0] field_number;
      logic                  field_truncated;
      logic                  line_end;
   } result_type;

   // space, tab, LF, VT, FF, CR
   function automatic logic is_ws(input logic [ByteWidth-1:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic field_kind_type kind_of_mode(input scan_mode_type m);
      field_kind_type k;
      case (m)
         MODE_QUOTE, MODE_ESCAPE: k = KIND_QUOTED;
         MODE_BRACKET:            k = KIND_BRACKET;
         default:                 k = KIND_BARE;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// File: rtl/alft_csr.sv
// Configuration registers of the tokenizer: parse limit and per-field cap.
// Depends on alft_pkg.
`default_nettype none

module alft_csr import alft_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [LimitWidth-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   logic [LimitWidth-1:0] max_line_ff, max_line_in;
   logic [LimitWidth-1:0] max_field_ff, max_field_in;

   assign csr_ready = 1'b1;

   always_comb begin
      max_line_in  = max_line_ff;
      max_field_in = max_field_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_LINE:  max_line_in  = csr_wdata;
            CSR_MAX_FIELD: max_field_in = csr_wdata;
            default: ; // unmapped index, write ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff  <= MAX_LINE_RESET;
         max_field_ff <= MAX_FIELD_RESET;
      end else begin
         max_line_ff  <= max_line_in;
         max_field_ff <= max_field_in;
      end
   end

   assign cfg.line_limit = max_line_ff;
   assign cfg.field_cap  = max_field_ff;

endmodule

`default_nettype wire

// File: rtl/alft_scan.sv
// Per-line scan state and the single-pass byte classifier.
// Depends on alft_pkg; state advances on each word taken from the input register.
`default_nettype none

module alft_scan import alft_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [ByteWidth-1:0] data_byte,
   input  wire logic                 line_last,
   input  cfg_type                   cfg,
   output logic                      emit,
   output result_type                result
);

   scan_mode_type          mode_ff, mode_in;
   logic [LimitWidth-1:0]  line_count_ff, line_count_in;
   logic [LimitWidth-1:0]  kept_count_ff, kept_count_in;
   logic                   drop_ff, drop_in;
   logic [FieldWidth-1:0]  field_ff, field_in;

   logic at_end;
   logic keep;
   logic fend;

   assign at_end = line_last ||
      (({1'b0, line_count_ff} + 17'd1) >= {1'b0, cfg.line_limit});

   always_comb begin
      mode_in       = mode_ff;
      line_count_in = line_count_ff;
      kept_count_in = kept_count_ff;
      drop_in       = drop_ff;
      field_in      = field_ff;
      keep          = 1'b0;
      fend          = 1'b0;

      result.has_byte        = 1'b0;
      result.out_byte        = '0;
      result.field_end       = 1'b0;
      result.field_kind      = KIND_BARE;
      result.field_number    = field_ff;
      result.field_truncated = 1'b0;
      result.line_end        = line_last;

      if (line_count_ff < cfg.line_limit) begin
         line_count_in = line_count_ff + 16'd1;
         unique case (mode_ff)
            MODE_BETWEEN: begin
               if (is_ws(data_byte)) begin
                  mode_in = MODE_BETWEEN;
               end else if (data_byte == CH_QUOTE) begin
                  mode_in = MODE_QUOTE;
               end else if (data_byte == CH_OPEN_BR) begin
                  mode_in = MODE_BRACKET;
               end else begin
                  mode_in = MODE_BARE;
                  keep    = 1'b1;
               end
            end
            MODE_BARE: begin
               if (is_ws(data_byte)) fend = 1'b1;
               else                  keep = 1'b1;
            end
            MODE_QUOTE: begin
               if (data_byte == CH_BACKSLASH) begin
                  // a trailing backslash at the close is kept as content
                  if (at_end) keep    = 1'b1;
                  else        mode_in = MODE_ESCAPE;
               end else if (data_byte == CH_QUOTE) begin
                  fend = 1'b1;
               end else begin
                  keep = 1'b1;
               end
            end
            MODE_ESCAPE: begin
               keep    = 1'b1;
               mode_in = MODE_QUOTE;
            end
            MODE_BRACKET: begin
               if (data_byte == CH_CLOSE_BR) fend = 1'b1;
               else                          keep = 1'b1;
            end
            default: mode_in = MODE_BETWEEN;
         endcase

         result.field_kind = kind_of_mode(mode_in);

         if (keep) begin
            if (kept_count_ff < cfg.field_cap) begin
               result.has_byte = 1'b1;
               result.out_byte = data_byte;
               kept_count_in   = kept_count_ff + 16'd1;
            end else begin
               drop_in = 1'b1;
            end
         end

         if (at_end && mode_in != MODE_BETWEEN) fend = 1'b1;

         if (fend) begin
            result.field_truncated = drop_in;
            if (field_ff != FIELD_MAX) field_in = field_ff + 8'd1;
            kept_count_in = '0;
            drop_in       = 1'b0;
            mode_in       = MODE_BETWEEN;
         end
      end

      result.field_end = fend;

      if (line_last) begin
         mode_in       = MODE_BETWEEN;
         line_count_in = '0;
         kept_count_in = '0;
         drop_in       = 1'b0;
         field_in      = '0;
      end
   end

   assign emit = result.has_byte || fend || line_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_BETWEEN;
         line_count_ff <= '0;
         kept_count_ff <= '0;
         drop_ff       <= 1'b0;
         field_ff      <= '0;
      end else if (step) begin
         mode_ff       <= mode_in;
         line_count_ff <= line_count_in;
         kept_count_ff <= kept_count_in;
         drop_ff       <= drop_in;
         field_ff      <= field_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/access_log_field_tokenizer_core.sv
// Path: an accepted word is held in the input register, and its result goes on to the
// result register, from which the result side takes it.
// Throughput: one byte per cycle while the result side does not stall;
// bytes that give no result still pass.
// Reset (synchronous, active high) empties both registers, clears the line state
// and loads a parse limit of 8192 bytes and a field cap of 4096 bytes.
`default_nettype none

module access_log_field_tokenizer_core import alft_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [ByteWidth-1:0]   req_data_byte,
   input  wire logic                   req_line_last,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_has_byte,
   output logic [ByteWidth-1:0]        rsp_out_byte,
   output logic                        rsp_field_end,
   output logic [1:0]                  rsp_field_kind,
   output logic [FieldWidth-1:0]       rsp_field_number,
   output logic                        rsp_field_truncated,
   output logic                        rsp_line_end,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [LimitWidth-1:0]  csr_wdata
);

   cfg_type    cfg;
   result_type result;
   logic       emit;
   logic       advance;

   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 in_last_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff;

   alft_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   alft_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .line_last (in_last_ff),
      .cfg       (cfg),
      .emit      (emit),
      .result    (result)
   );

   // the held word moves on once the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (advance)           in_valid_in = 1'b0;

      out_valid_in = out_valid_ff && !rsp_ready;
      if (advance) out_valid_in = emit || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_line_last;
      end
      if (advance && emit) out_ff <= result;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_has_byte        = out_ff.has_byte;
   assign rsp_out_byte        = out_ff.out_byte;
   assign rsp_field_end       = out_ff.field_end;
   assign rsp_field_kind      = out_ff.field_kind;
   assign rsp_field_number    = out_ff.field_number;
   assign rsp_field_truncated = out_ff.field_truncated;
   assign rsp_line_end        = out_ff.line_end;

endmodule

`default_nettype wire

// File: rtl/alft_checker.sv
// Port-level checks on the tokenizer's result channel, bound to the top level.
// No package dependency; sees only the top-level ports.
`default_nettype none

module alft_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_has_byte,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_field_end,
   input wire logic [1:0] rsp_field_kind,
   input wire logic       rsp_field_truncated,
   input wire logic       rsp_line_end
);

   // every word on the result side carries something
   a_rsp_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_byte || rsp_field_end || rsp_line_end))
      else $error("result word with no byte, field end or line end");

   // truncation is only reported as a field closes
   a_trunc_with_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_field_truncated) |-> rsp_field_end)
      else $error("truncation flag without field end");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_byte) |-> (rsp_out_byte == 8'h00))
      else $error("out byte not zero without a kept byte");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_field_kind) && $stable(rsp_field_end)))
      else $error("stalled result word changed");

endmodule

bind access_log_field_tokenizer_core alft_checker u_alft_checker (.*);

`default_nettype wire

// File: tb/access_log_field_tokenizer_core_tb.sv
// Self-checking bench for access_log_field_tokenizer_core: log lines go in one word per
// byte, each result word is checked against a line tokenizer kept in a small class.
// Depends on alft_pkg and the core RTL only.
`default_nettype none

module access_log_field_tokenizer_core_tb;
   import alft_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned RANDOM_WORDS = 1800;
   localparam int unsigned SETTLE       = 4;

   localparam logic [ByteWidth-1:0]   CH_SPACE   = 8'h20;
   localparam logic [ByteWidth-1:0]   CH_TAB     = 8'h09;
   localparam logic [ByteWidth-1:0]   CH_LF      = 8'h0A;
   localparam logic [ByteWidth-1:0]   CH_VT      = 8'h0B;
   localparam logic [ByteWidth-1:0]   CH_FF      = 8'h0C;
   localparam logic [ByteWidth-1:0]   CH_CR      = 8'h0D;
   localparam logic [CsrIdxWidth-1:0] CSR_UNUSED = 8'd2;

   typedef logic [ByteWidth-1:0] byte_queue_type[$];

   class field_token_checker_type;
      int unsigned    line_limit;
      int unsigned    field_cap;
      scan_mode_type  mode;
      int unsigned    line_pos;
      int unsigned    kept_bytes;
      bit             dropped;
      int unsigned    fields_closed;
      result_type     expected_tokens[$];
      int unsigned    errors;

      function new();
         line_limit = MAX_LINE_RESET;
         field_cap  = MAX_FIELD_RESET;
         errors     = 0;
         clear_line();
      endfunction

      function void clear_line();
         mode          = MODE_BETWEEN;
         line_pos      = 0;
         kept_bytes    = 0;
         dropped       = 1'b0;
         fields_closed = 0;
      endfunction

      function bit is_blank(logic [ByteWidth-1:0] b);
         return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
      endfunction

      function void set_reg(logic [CsrIdxWidth-1:0] idx, logic [LimitWidth-1:0] val);
         if (idx == CSR_MAX_LINE) line_limit = val;
         else if (idx == CSR_MAX_FIELD) field_cap = val;
      endfunction

      function int unsigned pending();
         return expected_tokens.size();
      endfunction

      function string show(result_type r);
         return $sformatf("has=%0d byte=%02h end=%0d kind=%0d num=%0d trunc=%0d last=%0d",
                          r.has_byte, r.out_byte, r.field_end, r.field_kind,
                          r.field_number, r.field_truncated, r.line_end);
      endfunction

      // one accepted input word
      function void note_byte(logic [ByteWidth-1:0] b, logic last);
         result_type     r;
         bit             keep;
         bit             fend;
         bit             at_end;
         field_kind_type kind;
         r      = '0;
         keep   = 1'b0;
         fend   = 1'b0;
         kind   = KIND_BARE;
         r.field_number = fields_closed[FieldWidth-1:0];
         if (line_pos < line_limit) begin
            at_end = last || (line_pos + 1 >= line_limit);
            line_pos++;
            case (mode)
               MODE_BETWEEN: begin
                  if (!is_blank(b)) begin
                     if (b == CH_QUOTE) mode = MODE_QUOTE;
                     else if (b == CH_OPEN_BR) mode = MODE_BRACKET;
                     else begin
                        mode = MODE_BARE;
                        keep = 1'b1;
                     end
                  end
               end
               MODE_BARE: begin
                  if (is_blank(b)) fend = 1'b1;
                  else keep = 1'b1;
               end
               MODE_QUOTE: begin
                  if (b == CH_BACKSLASH) begin
                     // a backslash on the closing byte is kept as it is
                     if (at_end) keep = 1'b1;
                     else mode = MODE_ESCAPE;
                  end else if (b == CH_QUOTE) begin
                     fend = 1'b1;
                  end else begin
                     keep = 1'b1;
                  end
               end
               MODE_ESCAPE: begin
                  keep = 1'b1;
                  mode = MODE_QUOTE;
               end
               MODE_BRACKET: begin
                  if (b == CH_CLOSE_BR) fend = 1'b1;
                  else keep = 1'b1;
               end
               default: mode = MODE_BETWEEN;
            endcase
            case (mode)
               MODE_QUOTE, MODE_ESCAPE: kind = KIND_QUOTED;
               MODE_BRACKET:            kind = KIND_BRACKET;
               default:                 kind = KIND_BARE;
            endcase
            if (keep) begin
               if (kept_bytes < field_cap) begin
                  r.has_byte = 1'b1;
                  r.out_byte = b;
                  kept_bytes++;
               end else begin
                  dropped = 1'b1;
               end
            end
            if (at_end && mode != MODE_BETWEEN) fend = 1'b1;
            if (fend) begin
               r.field_truncated = dropped;
               if (fields_closed < 255) fields_closed++;
               kept_bytes = 0;
               dropped    = 1'b0;
               mode       = MODE_BETWEEN;
            end
         end
         r.field_end  = fend;
         r.field_kind = kind;
         r.line_end   = last;
         if (r.has_byte || fend || last) expected_tokens = {expected_tokens, r};
         if (last) clear_line();
      endfunction

      function void check_token(result_type got);
         result_type want;
         if (expected_tokens.size() == 0) begin
            if (errors < 10) $display("unexpected result word: %s", show(got));
            errors++;
            return;
         end
         want = expected_tokens.pop_front();
         if (got.has_byte !== want.has_byte || got.out_byte !== want.out_byte ||
             got.field_end !== want.field_end || got.field_kind !== want.field_kind ||
             got.field_number !== want.field_number ||
             got.field_truncated !== want.field_truncated ||
             got.line_end !== want.line_end) begin
            if (errors < 10) begin
               $display("result mismatch: expected %s", show(want));
               $display("                 actual   %s", show(got));
            end
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [ByteWidth-1:0]   req_data_byte;
   logic                   req_line_last;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_has_byte;
   logic [ByteWidth-1:0]   rsp_out_byte;
   logic                   rsp_field_end;
   logic [1:0]             rsp_field_kind;
   logic [FieldWidth-1:0]  rsp_field_number;
   logic                   rsp_field_truncated;
   logic                   rsp_line_end;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [LimitWidth-1:0]  csr_wdata;

   field_token_checker_type tokens = new();
   int unsigned        cycles     = 0;
   int unsigned        words_sent = 0;
   bit                 req_calm   = 1'b0;
   bit                 rsp_calm   = 1'b0;

   access_log_field_tokenizer_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_line_last       (req_line_last),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_has_byte        (rsp_has_byte),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_field_end       (rsp_field_end),
      .rsp_field_kind      (rsp_field_kind),
      .rsp_field_number    (rsp_field_number),
      .rsp_field_truncated (rsp_field_truncated),
      .rsp_line_end        (rsp_line_end),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_word(input logic [ByteWidth-1:0] b, input logic last);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_line_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tokens.note_byte(b, last);
      words_sent++;
   endtask

   task automatic send_line(input byte_queue_type line, input bit close);
      foreach (line[i]) send_word(line[i], close && (i == line.size() - 1));
   endtask

   // hold off the sender until every result word is out, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      while (tokens.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CsrIdxWidth-1:0] idx, input logic [LimitWidth-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tokens.set_reg(idx, val);
   endtask

   task automatic set_limits(input logic [LimitWidth-1:0] line_lim,
                             input logic [LimitWidth-1:0] field_lim);
      drain();
      csr_put(CSR_MAX_LINE, line_lim);
      csr_put(CSR_MAX_FIELD, field_lim);
      csr_valid <= 1'b0;
   endtask

   task automatic compose_line(output byte_queue_type line, input int unsigned target);
      logic [ByteWidth-1:0] b;
      int unsigned          n;
      line = {};
      while (line.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               n = $urandom_range(1, 6);
               repeat (n) begin
                  do b = ByteWidth'($urandom_range(0, 255)); while (tokens.is_blank(b));
                  line = {line, b};
               end
            end
            4, 5: begin
               line = {line, CH_QUOTE};
               n = $urandom_range(0, 6);
               repeat (n) begin
                  if ($urandom_range(0, 4) == 0) begin
                     line = {line, CH_BACKSLASH};
                     line = {line, ByteWidth'($urandom_range(0, 255))};
                  end else begin
                     do b = ByteWidth'($urandom_range(0, 255));
                     while (b == CH_QUOTE || b == CH_BACKSLASH);
                     line = {line, b};
                  end
               end
               if ($urandom_range(0, 9) != 0) line = {line, CH_QUOTE};
            end
            6, 7: begin
               line = {line, CH_OPEN_BR};
               n = $urandom_range(0, 6);
               repeat (n) begin
                  do b = ByteWidth'($urandom_range(0, 255)); while (b == CH_CLOSE_BR);
                  line = {line, b};
               end
               if ($urandom_range(0, 9) != 0) line = {line, CH_CLOSE_BR};
            end
            default: begin
               n = $urandom_range(1, 3);
               repeat (n) line = {line, ByteWidth'($urandom_range(0, 255))};
            end
         endcase
         n = $urandom_range(0, 2);
         repeat (n) begin
            b = ByteWidth'($urandom_range(0, 5));
            line = {line, (b == 5) ? CH_SPACE : CH_TAB + b};
         end
      end
      // cutting at the target leaves broken tails too
      while (line.size() > target) void'(line.pop_back());
   endtask

   initial begin : result_monitor
      int unsigned stall;
      result_type  got;
      rsp_ready <= 1'b0;
      wait (reset === 1'b1);
      wait (reset === 1'b0);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got                 = '0;
         got.has_byte        = rsp_has_byte;
         got.out_byte        = rsp_out_byte;
         got.field_end       = rsp_field_end;
         got.field_kind      = field_kind_type'(rsp_field_kind);
         got.field_number    = rsp_field_number;
         got.field_truncated = rsp_field_truncated;
         got.line_end        = rsp_line_end;
         tokens.check_token(got);
      end
   end

   initial begin : stimulus
      byte_queue_type        line;
      int unsigned           lim;
      int unsigned           cap;
      int unsigned           phase;
      int unsigned           n_lines;
      int unsigned           len;
      bit                    open_end;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= '0;
      req_line_last <= 1'b0;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: byte extremes, every field kind, escaped quote, empty fields,
      // a line closing with no field open, trailing backslash at line end
      line = {8'h00, 8'hFF, 8'h08, CH_SPACE, CH_QUOTE, CH_BACKSLASH, CH_QUOTE, 8'h0E,
              CH_QUOTE, CH_CR, CH_OPEN_BR, CH_QUOTE, CH_CLOSE_BR, CH_LF, CH_QUOTE,
              CH_QUOTE, CH_FF, CH_OPEN_BR, CH_CLOSE_BR, CH_VT};
      send_line(line, 1'b1);
      line = {CH_QUOTE, 8'h71, CH_BACKSLASH};
      send_line(line, 1'b1);
      // parse limit and field cap together
      set_limits(16'd3, 16'd1);
      line = {8'h61, 8'h62, 8'h63, 8'h64};
      send_line(line, 1'b1);

      words_sent = 0;
      phase      = 0;
      while (words_sent < RANDOM_WORDS) begin
         case (phase)
            0: begin lim = MAX_LINE_RESET; cap = MAX_FIELD_RESET; end
            1: begin lim = 16'd0; cap = $urandom_range(0, 65535); end
            2: begin lim = 16'hFFFF; cap = 16'd0; end
            3: begin lim = 16'hFFFF; cap = 16'hFFFF; end
            4: begin lim = 16'd1; cap = 16'd1; end
            default: begin
               case ($urandom_range(0, 3))
                  0: begin lim = $urandom_range(1, 40); cap = $urandom_range(0, 8); end
                  1: begin lim = $urandom_range(0, 65535); cap = $urandom_range(0, 65535); end
                  2: begin lim = $urandom_range(1, 60); cap = $urandom_range(1, 20); end
                  default: begin lim = 16'hFFFF; cap = $urandom_range(0, 6); end
               endcase
            end
         endcase
         set_limits(LimitWidth'(lim), LimitWidth'(cap));
         if (phase == 6) begin
            csr_put(CSR_UNUSED, LimitWidth'($urandom_range(0, 65535)));
            csr_valid <= 1'b0;
         end
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         if (phase == 3) begin
            // enough fields to saturate the field index
            line = {};
            repeat (300) begin
               line = {line, ByteWidth'(8'h61 + $urandom_range(0, 25))};
               line = {line, CH_SPACE};
            end
            send_line(line, 1'b1);
            drain();
         end
         n_lines  = $urandom_range(4, 12);
         // sometimes the last line runs on past the next register change
         open_end = ($urandom_range(0, 2) == 0);
         for (int k = 0; k < n_lines; k++) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 40);
            compose_line(line, len);
            send_line(line, !(open_end && k == n_lines - 1));
         end
         phase++;
      end

      drain();
      repeat (8) @(posedge clock);
      if (tokens.errors == 0 && tokens.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/alft_pkg.sv
rtl/alft_csr.sv
rtl/alft_scan.sv
rtl/access_log_field_tokenizer_core.sv
rtl/alft_checker.sv
tb/access_log_field_tokenizer_core_tb.sv
